// ===== hw/rtl/spwm_pkg.sv =====
// shared types and constants for the servo pulse generator with ascii commands
`timescale 1ns / 1ps

package spwm_pkg;

   localparam int ACCUMULATOR_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_BASE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ANGLE    = 2'd2;

   localparam logic [7:0] PERIOD_TICKS_RESET = 8'd200;
   localparam logic [7:0] PULSE_BASE_RESET   = 8'd5;
   localparam logic [7:0] MAX_ANGLE_RESET    = 8'd180;

   localparam logic       MODE_TICK = 1'b0;
   localparam logic       MODE_BYTE = 1'b1;

   localparam logic [7:0] CHAR_START = 8'h53;
   localparam logic [7:0] CHAR_END   = 8'h45;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } spwm_req_type;

   typedef struct packed {
      logic       servo_level;
      logic [7:0] angle;
      logic       command_accepted;
      logic       command_rejected;
   } spwm_rsp_type;

   // angle / 12 as ((angle >> 2) * 43) >> 7, exact for all 8-bit angles
   function automatic logic [4:0] angle_div12(input logic [7:0] angle);
      logic [11:0] prod;
      prod = 12'(angle[7:2]) * 12'd43;
      return prod[11:7];
   endfunction

endpackage

// ===== hw/rtl/spwm_in_stage.sv =====
// input register stage for request transfers
`timescale 1ns / 1ps

module spwm_in_stage
   import spwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  spwm_req_type req_data,
   input  logic         advance,
   output logic         item_valid,
   output spwm_req_type item_data
);

   logic         valid_ff;
   logic         valid_in;
   spwm_req_type data_ff;
   logic         load;

   assign req_stall  = valid_ff & ~advance;
   assign load       = req_valid & ~req_stall;
   assign valid_in   = load | (valid_ff & ~advance);
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

endmodule

// ===== hw/rtl/spwm_core.sv =====
// servo state, command parser and configuration registers
`timescale 1ns / 1ps

module spwm_core
   import spwm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       fire,
   input  spwm_req_type               item_data,
   output spwm_rsp_type               result
);

   logic [7:0]                   period_ticks_ff;
   logic [7:0]                   pulse_base_ff;
   logic [7:0]                   max_angle_ff;

   logic [7:0]                   phase_ff,      phase_in;
   logic [7:0]                   angle_ff,      angle_in;
   logic [ACCUMULATOR_WIDTH-1:0] acc_ff,        acc_in;
   logic                         collecting_ff, collecting_in;
   logic                         level_ff,      level_in;

   logic [8:0]                   phase_next;
   logic [8:0]                   high_ticks;
   logic [ACCUMULATOR_WIDTH-1:0] digit;
   logic                         cmd_ok;
   logic                         cmd_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff <= PERIOD_TICKS_RESET;
         pulse_base_ff   <= PULSE_BASE_RESET;
         max_angle_ff    <= MAX_ANGLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PERIOD_TICKS: period_ticks_ff <= csr_wdata;
            CSR_PULSE_BASE:   pulse_base_ff   <= csr_wdata;
            CSR_MAX_ANGLE:    max_angle_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign phase_next = {1'b0, phase_ff} + 9'd1;
   assign high_ticks = 9'(angle_div12(angle_ff)) + {1'b0, pulse_base_ff};
   assign digit      = {{(ACCUMULATOR_WIDTH-8){1'b0}}, item_data.rx_byte}
                       - ACCUMULATOR_WIDTH'(CHAR_ZERO);

   always_comb begin
      phase_in      = phase_ff;
      angle_in      = angle_ff;
      acc_in        = acc_ff;
      collecting_in = collecting_ff;
      level_in      = level_ff;
      cmd_ok        = 1'b0;
      cmd_bad       = 1'b0;
      priority if (item_data.mode == MODE_TICK) begin
         phase_in = (phase_next >= {1'b0, period_ticks_ff}) ? 8'd0 : phase_next[7:0];
         level_in = {1'b0, phase_in} < high_ticks;
      end else if (item_data.rx_byte == CHAR_START) begin
         collecting_in = 1'b1;
         acc_in        = '0;
      end else begin
         if (collecting_ff) begin
            if (item_data.rx_byte == CHAR_END) begin
               collecting_in = 1'b0;
               if (acc_ff <= ACCUMULATOR_WIDTH'(max_angle_ff)) begin
                  angle_in = acc_ff[7:0];
                  cmd_ok   = 1'b1;
               end else begin
                  cmd_bad = 1'b1;
               end
            end else begin
               acc_in = (acc_ff << 3) + (acc_ff << 1) + digit;
            end
         end
      end
   end

   assign result.servo_level      = level_in;
   assign result.angle            = angle_in;
   assign result.command_accepted = cmd_ok;
   assign result.command_rejected = cmd_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         angle_ff      <= '0;
         acc_ff        <= '0;
         collecting_ff <= 1'b0;
         level_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         angle_ff      <= angle_in;
         acc_ff        <= acc_in;
         collecting_ff <= collecting_in;
         level_ff      <= level_in;
      end
   end

endmodule

// ===== hw/rtl/spwm_out_stage.sv =====
// result register for response transfers
`timescale 1ns / 1ps

module spwm_out_stage
   import spwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  spwm_rsp_type result,
   output logic         advance,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output spwm_rsp_type rsp_data
);

   logic         valid_ff;
   logic         valid_in;
   spwm_rsp_type data_ff;
   logic         load;

   assign advance   = ~valid_ff | ~rsp_stall;
   assign load      = item_valid & advance;
   assign valid_in  = load | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

// ===== hw/rtl/servo_pwm_with_ascii_command_top.sv =====
// a request transfer passes the input register and then the result register before its response shows
// throughput: one item per cycle, held back only by rsp_stall through the result register
// each item is handled in one pass between the input register and the result register
// reset: synchronous, clears both stages, phase, angle, accumulator, command state, line level
// reset also restores period_ticks 200, pulse_base 5, max_angle 180
`timescale 1ns / 1ps

module servo_pwm_with_ascii_command_top
   import spwm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  spwm_req_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output spwm_rsp_type               rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic         advance;
   logic         item_valid;
   spwm_req_type item_data;
   spwm_rsp_type result;

   spwm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   spwm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (item_valid & advance),
      .item_data (item_data),
      .result    (result)
   );

   spwm_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hw/rtl/spwm_checker.sv =====
// port-level assertions for the servo pulse generator, bound to the top level
`timescale 1ns / 1ps

module spwm_checker
   import spwm_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input spwm_rsp_type               rsp_data
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a response never flags a command as both accepted and rejected
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.command_accepted && rsp_data.command_rejected))
      else $error("command both accepted and rejected");

   // an idle pipeline never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid ##1 !rsp_valid |-> !req_stall)
      else $error("request stalled with empty pipeline");

endmodule

bind servo_pwm_with_ascii_command_top spwm_checker u_spwm_checker (.*);

// ===== bench/tb_servo_pwm_with_ascii_command_top.sv =====
// self-checking testbench for the servo pulse generator with ascii commands
`timescale 1ns / 1ps

module tb_servo_pwm_with_ascii_command_top;
   import spwm_pkg::*;

   localparam int ANGLE_STEP       = 12;
   localparam int PHASES           = 6;
   localparam int ITEMS_PER_PHASE  = 205;
   localparam int HOLD_CYCLES      = 80;
   localparam int SETTLE_CYCLES    = 4;
   localparam int QUIET_LIMIT      = 2000;

   class servo_scoreboard;
      logic [7:0]                   period_ticks;
      logic [7:0]                   pulse_base;
      logic [7:0]                   max_angle;
      logic [7:0]                   phase;
      logic [7:0]                   angle_reg;
      logic [ACCUMULATOR_WIDTH-1:0] accumulator;
      logic                         collecting;
      logic                         level;
      spwm_rsp_type                 pending_rsp[$];
      int errors, items, checked, loaded, refused, high_ticks;

      function new();
         period_ticks = PERIOD_TICKS_RESET;
         pulse_base   = PULSE_BASE_RESET;
         max_angle    = MAX_ANGLE_RESET;
         phase        = '0;
         angle_reg    = '0;
         accumulator  = '0;
         collecting   = 1'b0;
         level        = 1'b0;
         errors = 0; items = 0; checked = 0; loaded = 0; refused = 0; high_ticks = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [7:0] value);
         case (index)
            CSR_PERIOD_TICKS: period_ticks = value;
            CSR_PULSE_BASE:   pulse_base = value;
            CSR_MAX_ANGLE:    max_angle = value;
            default: ;
         endcase
      endfunction

      function void note_request(spwm_req_type req);
         spwm_rsp_type rsp;
         int unsigned  next_phase;
         int unsigned  width;
         rsp = '0;
         if (req.mode == MODE_TICK) begin
            next_phase = phase + 1;
            phase = (next_phase >= period_ticks) ? 8'd0 : next_phase[7:0];
            width = angle_reg / ANGLE_STEP + pulse_base;
            level = (phase < width);
            if (level) high_ticks++;
         end else if (req.rx_byte == CHAR_START) begin
            collecting = 1'b1;
            accumulator = '0;
         end else if (collecting) begin
            if (req.rx_byte == CHAR_END) begin
               if (accumulator <= max_angle) begin
                  angle_reg = accumulator[7:0];
                  rsp.command_accepted = 1'b1;
                  loaded++;
               end else begin
                  rsp.command_rejected = 1'b1;
                  refused++;
               end
               collecting = 1'b0;
            end else begin
               accumulator = accumulator * 16'd10 + {8'd0, req.rx_byte} - {8'd0, CHAR_ZERO};
            end
         end
         rsp.servo_level = level;
         rsp.angle = angle_reg;
         pending_rsp.push_back(rsp);
         items++;
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(spwm_rsp_type got);
         spwm_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("servo_level", 8'(want.servo_level), 8'(got.servo_level));
            compare_field("angle", want.angle, got.angle);
            compare_field("command_accepted", 8'(want.command_accepted),
                          8'(got.command_accepted));
            compare_field("command_rejected", 8'(want.command_rejected),
                          8'(got.command_rejected));
            checked++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   spwm_req_type               req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   spwm_rsp_type               rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   servo_scoreboard sb;
   spwm_req_type    plan[$];
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_requests = 0;
   int              hold_served = 0;
   int              hold_left = 0;
   int              quiet_cycles = 0;

   servo_pwm_with_ascii_command_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: check each transfer, then pick the next stall
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("** servo_pwm_with_ascii_command_top: FAILED **");
            $finish;
         end
      end
   end

   function automatic spwm_req_type tick_item(logic [7:0] b);
      spwm_req_type item;
      item.mode = MODE_TICK;
      item.rx_byte = b;
      return item;
   endfunction

   function automatic spwm_req_type char_item(logic [7:0] b);
      spwm_req_type item;
      item.mode = MODE_BYTE;
      item.rx_byte = b;
      return item;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) plan.push_back(char_item(s[i]));
   endfunction

   function automatic logic [7:0] digit_char();
      return CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   // mostly well-formed commands mixed with ticks, some broken commands and noise
   function automatic void plan_chunk();
      int pick;
      int digits;
      pick = $urandom_range(99);
      if (pick < 35) begin
         repeat ($urandom_range(8, 1)) plan.push_back(tick_item(8'($urandom_range(255))));
      end else if (pick < 78) begin
         plan.push_back(char_item(CHAR_START));
         digits = ($urandom_range(99) < 10) ? $urandom_range(5, 4) : $urandom_range(3, 0);
         repeat (digits) begin
            plan.push_back(char_item(digit_char()));
            if ($urandom_range(9) == 0) plan.push_back(tick_item(8'($urandom_range(255))));
         end
         plan.push_back(char_item(CHAR_END));
      end else if (pick < 90) begin
         plan.push_back(char_item(CHAR_START));
         repeat ($urandom_range(3)) plan.push_back(char_item(digit_char()));
         case ($urandom_range(2))
            0: plan.push_back(char_item(8'($urandom_range(255))));
            1: plan.push_back(char_item(CHAR_START));
            default: ;
         endcase
      end else begin
         repeat ($urandom_range(3, 1)) plan.push_back(char_item(8'($urandom_range(255))));
      end
   endfunction

   task automatic send_item(spwm_req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [7:0] period, logic [7:0] base, logic [7:0] limit);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PERIOD_TICKS;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_PULSE_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_MAX_ANGLE;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(CSR_PERIOD_TICKS, period);
      sb.write_reg(CSR_PULSE_BASE, base);
      sb.write_reg(CSR_MAX_ANGLE, limit);
   endtask

   initial begin
      int sent;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings
      plan.push_back(tick_item(8'hFF));
      plan.push_back(char_item(8'h00));
      plan.push_back(char_item(8'hFF));
      add_text("ES90E");
      plan.push_back(tick_item(8'h00));
      add_text("S9S181ESAES");
      plan.push_back(char_item(8'h00));
      add_text("ESE");
      plan.push_back(tick_item(8'h5A));
      while (plan.size() != 0) send_item(plan.pop_front());

      for (int p = 0; p < PHASES; p++) begin
         wait_drain();
         case (p)
            0: write_settings(8'd2, 8'd0, 8'd255);
            1: write_settings(8'd255, 8'd255, 8'd0);
            2: write_settings(8'd0, 8'd3, 8'd180);
            3: write_settings(8'd1, 8'd0, 8'd90);
            default: write_settings(8'($urandom_range(40, 2)), 8'($urandom_range(20)),
                                    8'($urandom_range(255)));
         endcase
         case (p)
            2: begin send_idle_pct = 62; stall_pct = 0; end
            3: begin send_idle_pct = 0; stall_pct = 62; end
            4: begin send_idle_pct = 25; stall_pct = 25; end
            5: begin send_idle_pct = $urandom_range(40); stall_pct = $urandom_range(40); end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if (plan.size() == 0) plan_chunk();
            send_item(plan.pop_front());
            sent++;
            // long receiver hold while the sender keeps offering
            if (p == 1 && sent == 40) hold_requests++;
            if (p == 1 && sent == 120) wait_drain();
         end
      end

      wait_drain();
      $display("%0d items sent, %0d results checked over %0d settings and idle mixes",
               sb.items, sb.checked, PHASES + 1);
      $display("%0d commands loaded, %0d refused, %0d ticks with the line high",
               sb.loaded, sb.refused, sb.high_ticks);
      if (sb.errors == 0) begin
         $display("** servo_pwm_with_ascii_command_top: PASSED **");
      end else begin
         $display("** servo_pwm_with_ascii_command_top: FAILED **");
      end
      $finish;
   end

endmodule
